// ----- hdl/strict_base85_decoder_core_macros.svh -----
// Assertion macros for the strict base-85 decoder.
// Expects clk and rst_n in the scope of the use.
`ifndef STRICT_BASE85_DECODER_CORE_MACROS_SVH
`define STRICT_BASE85_DECODER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SB85_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define SB85_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- hdl/sb85_pkg.sv -----
// Shared types, constants and lookup functions for the base-85 decoder.
// No dependencies.
package sb85_pkg;

  localparam int POSITION_BITS = 32;
  localparam int RADIX         = 85;
  localparam int DIGIT_W       = 7;
  localparam int ACC_W         = 26;
  localparam int GROUP_W       = 33;
  localparam int WIDE_W        = GROUP_W + 1;
  localparam int WORD_W        = 32;
  localparam int CNT_W         = 3;
  localparam int SPAN_W        = 20;
  localparam int GROUP_DIGITS  = 5;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic CFG_IDX_ALPHA = 1'b0;

  localparam logic [8*RADIX-1:0] RFC_ALPHABET = {
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "abcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_", 8'h60, "{|}~"
  };
  localparam logic [8*RADIX-1:0] Z85_ALPHABET = {
    "0123456789abcdefghijklmnopqrstuvwxyz",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#"
  };

  typedef enum logic [1:0] {
    ERR_INVALID_CHAR = 2'd0,
    ERR_SHORT_TAIL   = 2'd1,
    ERR_GROUP_RANGE  = 2'd2,
    ERR_NONCANON     = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    JOB_ERROR = 2'd0,
    JOB_GROUP = 2'd1,
    JOB_TAIL  = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic              is_error;
    logic [1:0]        error_code;
    logic [7:0]        data_byte;
    logic [WORD_W-1:0] position;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    job_kind_t         kind;
    err_code_t         code;
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] position;
    logic              last;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] digit;
  } digit_t;

  function automatic digit_t digit_lookup(logic [7:0] ch, logic sel);
    digit_t               r;
    logic [8*RADIX-1:0]   tab;
    r   = '0;
    tab = sel ? Z85_ALPHABET : RFC_ALPHABET;
    for (int i = 0; i < RADIX; i++) begin
      if (tab[8*(RADIX-1-i) +: 8] == ch) begin
        r.hit   = 1'b1;
        r.digit = DIGIT_W'(i);
      end
    end
    return r;
  endfunction

  // weight of the zero digits that pad a tail of the given length
  function automatic logic [SPAN_W-1:0] span_of(logic [CNT_W-1:0] count);
    logic [SPAN_W-1:0] s;
    unique case (count)
      CNT_W'(2): s = SPAN_W'(614125);
      CNT_W'(3): s = SPAN_W'(7225);
      CNT_W'(4): s = SPAN_W'(85);
      default:   s = SPAN_W'(1);
    endcase
    return s;
  endfunction

  // low-order mask of the dropped bytes for a tail of payload bytes
  function automatic logic [WIDE_W-1:0] drop_mask(logic [1:0] payload);
    logic [WIDE_W-1:0] m;
    unique case (payload)
      2'd1:    m = WIDE_W'(24'hFF_FFFF);
      2'd2:    m = WIDE_W'(16'hFFFF);
      2'd3:    m = WIDE_W'(8'hFF);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/sb85_fifo.sv -----
// Short job queue between the front and back of the base-85 decoder.
// Depends on sb85_pkg.
module sb85_fifo
  import sb85_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_data,
  input  logic    pop,
  output job_t    pop_data,
  output q_stat_t q_stat
);

  job_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   fill_r, fill_nxt;

  assign q_stat.full  = (fill_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign q_stat.valid = (fill_r != '0);
  assign pop_data     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/sb85_front.sv -----
// Front of the base-85 decoder: maps characters to digits, accumulates
// groups, tracks position and errors, and queues jobs. Depends on sb85_pkg.
module sb85_front
  import sb85_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     alpha_sel,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output job_t     push_data
);

  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     err_seen_r, err_seen_nxt;
  digit_t                   dig;
  logic [GROUP_W-1:0]       acc_w;
  logic [GROUP_W-1:0]       grown;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign dig      = digit_lookup(in_data.character, alpha_sel);
  assign acc_w    = GROUP_W'(acc_r);
  // acc * 85 + digit
  assign grown    = (acc_w << 6) + (acc_w << 4) + (acc_w << 2) + acc_w
                  + GROUP_W'(dig.digit);
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    acc_nxt            = acc_r;
    cnt_nxt            = cnt_r;
    pos_nxt            = pos_r;
    err_seen_nxt       = err_seen_r;
    push               = 1'b0;
    push_data          = '0;
    push_data.kind     = JOB_GROUP;
    push_data.code     = ERR_INVALID_CHAR;
    push_data.value    = WORD_W'(grown);
    push_data.count    = cnt_inc;
    push_data.position = WORD_W'(pos_r);
    push_data.last     = in_data.end_of_text;
    if (accept) begin
      if (!(&pos_r)) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (err_seen_r) begin
        push = 1'b0;
      end else if (!dig.hit) begin
        push           = 1'b1;
        push_data.kind = JOB_ERROR;
        push_data.code = ERR_INVALID_CHAR;
        err_seen_nxt   = 1'b1;
      end else if (cnt_inc == CNT_W'(GROUP_DIGITS)) begin
        push    = 1'b1;
        acc_nxt = '0;
        cnt_nxt = '0;
        if (grown[GROUP_W-1]) begin
          push_data.kind = JOB_ERROR;
          push_data.code = ERR_GROUP_RANGE;
          err_seen_nxt   = 1'b1;
        end
      end else if (in_data.end_of_text) begin
        push = 1'b1;
        if (cnt_inc == CNT_W'(1)) begin
          push_data.kind = JOB_ERROR;
          push_data.code = ERR_SHORT_TAIL;
        end else begin
          push_data.kind = JOB_TAIL;
        end
      end else begin
        acc_nxt = grown[ACC_W-1:0];
        cnt_nxt = cnt_inc;
      end
      if (in_data.end_of_text) begin
        acc_nxt      = '0;
        cnt_nxt      = '0;
        pos_nxt      = '0;
        err_seen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      cnt_r      <= '0;
      pos_r      <= '0;
      err_seen_r <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

endmodule

// ----- hdl/sb85_back.sv -----
// Back of the base-85 decoder: checks tails, forms error words and
// serialises data bytes into the output register. Depends on sb85_pkg.
module sb85_back
  import sb85_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  job_t      pop_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic                        s1_valid_r, s1_valid_nxt;
  job_t                        s1_job_r;
  logic [GROUP_W-1:0]          s1_prod_r;
  logic [ACC_W+SPAN_W-1:0]     prod_full;

  logic                        em_valid_r, em_valid_nxt;
  out_item_t                   em_r, em_nxt;
  logic [WORD_W-1:0]           word_r, word_nxt;
  logic [1:0]                  left_r, left_nxt;
  logic                        last_r, last_nxt;

  logic                        s2_free, s1_free;
  logic [1:0]                  payload;
  logic [WIDE_W-1:0]           umask, prod_wide, rounded, span_top;
  logic [WORD_W-1:0]           ld_word;
  logic [1:0]                  ld_left;
  logic                        ld_last;
  logic                        ld_err;
  err_code_t                   ld_code;

  assign s2_free   = !em_valid_r || (out_ready && left_r == 2'd0);
  assign s1_free   = !s1_valid_r || s2_free;
  assign pop       = q_stat.valid && s1_free;
  assign out_valid = em_valid_r;
  assign out_data  = em_r;

  assign prod_full = pop_data.value[ACC_W-1:0] * span_of(pop_data.count);

  // tail check: round up to the dropped-byte unit, stay within the span
  assign payload   = 2'(s1_job_r.count - 1'b1);
  assign umask     = drop_mask(payload);
  assign prod_wide = WIDE_W'(s1_prod_r);
  assign rounded   = (prod_wide + umask) & ~umask;
  assign span_top  = prod_wide + WIDE_W'(span_of(s1_job_r.count)) - 1'b1;

  always_comb begin
    ld_err  = 1'b0;
    ld_code = s1_job_r.code;
    ld_word = s1_job_r.value;
    ld_left = 2'd3;
    ld_last = s1_job_r.last;
    unique case (s1_job_r.kind)
      JOB_GROUP: begin
        ld_err = 1'b0;
      end
      JOB_TAIL: begin
        ld_last = 1'b1;
        if (s1_prod_r[GROUP_W-1]) begin
          ld_err  = 1'b1;
          ld_code = ERR_GROUP_RANGE;
        end else if (rounded > span_top || rounded[WIDE_W-1:WORD_W] != '0) begin
          ld_err  = 1'b1;
          ld_code = ERR_NONCANON;
        end else begin
          ld_word = rounded[WORD_W-1:0];
          ld_left = payload - 1'b1;
        end
      end
      default: begin
        ld_err = 1'b1;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    em_valid_nxt = em_valid_r;
    em_nxt       = em_r;
    word_nxt     = word_r;
    left_nxt     = left_r;
    last_nxt     = last_r;
    if (s1_free) begin
      s1_valid_nxt = pop;
    end
    if (s2_free) begin
      em_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        em_nxt = '0;
        if (ld_err) begin
          em_nxt.is_error    = 1'b1;
          em_nxt.error_code  = ld_code;
          em_nxt.position    = s1_job_r.position;
          em_nxt.last_result = 1'b1;
          left_nxt           = 2'd0;
        end else begin
          em_nxt.data_byte   = ld_word[WORD_W-1 -: 8];
          em_nxt.last_result = ld_last && (ld_left == 2'd0);
          word_nxt           = ld_word << 8;
          left_nxt           = ld_left;
          last_nxt           = ld_last;
        end
      end
    end else if (out_ready) begin
      em_nxt.data_byte   = word_r[WORD_W-1 -: 8];
      em_nxt.last_result = last_r && (left_r == 2'd1);
      word_nxt           = word_r << 8;
      left_nxt           = left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      em_valid_r <= 1'b0;
      left_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      em_valid_r <= em_valid_nxt;
      left_r     <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_job_r  <= pop_data;
      s1_prod_r <= GROUP_W'(prod_full);
    end
    em_r   <= em_nxt;
    word_r <= word_nxt;
    last_r <= last_nxt;
  end

endmodule

// ----- hdl/strict_base85_decoder_core.sv -----
// Strict base-85 decoder top level; depends on sb85_pkg, sb85_front,
// sb85_fifo, sb85_back and the macros header.
// Takes one character a cycle while the four-entry job queue has room; each
// job passes from the queue through the stage-1 register to the output
// register; results leave at one a cycle while out_ready is high (a full group gives four).
// Synchronous active-low reset clears all control state and selects RFC 1924.
`include "strict_base85_decoder_core_macros.svh"

module strict_base85_decoder_core
  import sb85_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  logic    alpha_sel_r, alpha_sel_nxt;
  logic    cfg_wr;
  logic    q_push, q_pop;
  job_t    q_push_data, q_pop_data;
  q_stat_t q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[PADDR_W-1:2] == CFG_IDX_ALPHA) ? PDATA_W'(alpha_sel_r) : '0;

  always_comb begin
    alpha_sel_nxt = alpha_sel_r;
    if (cfg_wr && cfg_paddr[PADDR_W-1:2] == CFG_IDX_ALPHA) begin
      alpha_sel_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_sel_r <= 1'b0;
    end else begin
      alpha_sel_r <= alpha_sel_nxt;
    end
  end

  sb85_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha_sel (alpha_sel_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_push_data)
  );

  sb85_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .q_stat    (q_stat)
  );

  sb85_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_data  (q_pop_data),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `SB85_ASSERT_IMP(a_no_q_overflow, q_push, !q_stat.full, "job pushed into full queue")
  `SB85_ASSERT_IMP(a_err_is_last, out_valid && out_data.is_error, out_data.last_result,
                   "error word not marked last")
  `SB85_ASSERT_NEVER(a_data_clean,
                     out_valid && !out_data.is_error &&
                     (out_data.position != '0 || out_data.error_code != '0),
                     "data word carries error fields")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for strict_base85_decoder_core: directed and random texts,
// predicted word by word and compared on the result channel.
// Depends on sb85_pkg and the core RTL only.
module tb_top;
  import sb85_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BASE        = 85;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam logic [63:0] U32_ALL_ONES = 64'h0000_0000_FFFF_FFFF;
  localparam logic [PADDR_W-1:0] ALPHA_ADDR = PADDR_W'(4 * int'(CFG_IDX_ALPHA));

  localparam logic [8*BASE-1:0] ALPHA_RFC = {
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "abcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_", 8'h60, "{|}~"
  };
  localparam logic [8*BASE-1:0] ALPHA_Z85 = {
    "0123456789abcdefghijklmnopqrstuvwxyz",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#"
  };

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  in_item_t           in_data     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  out_item_t          out_data;
  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr   = '0;
  logic [PDATA_W-1:0] cfg_pwdata  = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  strict_base85_decoder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // decoder shadow state
  bit          alpha_sel;
  logic [63:0] digit_acc;
  int unsigned digit_count;
  logic [31:0] char_index;
  bit          text_failed;
  int unsigned live_chars;

  out_item_t   pending_results[$];
  logic [7:0]  text_chars[$];
  int          mismatch_count;
  int          send_gap_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic string fmt_result(out_item_t r);
    return $sformatf("err=%0d code=%0d byte=%02h pos=%0d last=%0d",
                     r.is_error, r.error_code, r.data_byte, r.position, r.last_result);
  endfunction

  function automatic void flag(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  function automatic int digit_of(logic [7:0] ch, bit sel);
    logic [8*BASE-1:0] chars;
    chars = sel ? ALPHA_Z85 : ALPHA_RFC;
    for (int i = 0; i < BASE; i++) begin
      if (chars[8*(BASE-1-i) +: 8] == ch) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] alpha_char(int d, bit sel);
    logic [8*BASE-1:0] chars;
    chars = sel ? ALPHA_Z85 : ALPHA_RFC;
    return chars[8*(BASE-1-d) +: 8];
  endfunction

  function automatic void clear_text();
    digit_acc   = '0;
    digit_count = 0;
    char_index  = '0;
    text_failed = 1'b0;
  endfunction

  function automatic void push_byte(logic [7:0] b, bit last);
    out_item_t r;
    r             = '0;
    r.data_byte   = b;
    r.last_result = last;
    pending_results.push_back(r);
  endfunction

  function automatic void push_error(err_code_t code, logic [31:0] pos, bit eot);
    out_item_t r;
    r             = '0;
    r.is_error    = 1'b1;
    r.error_code  = code;
    r.position    = pos;
    r.last_result = 1'b1;
    pending_results.push_back(r);
    if (eot) clear_text();
    else text_failed = 1'b1;
  endfunction

  function automatic void decode_char(in_item_t it);
    logic [31:0] pos;
    int          d;
    int unsigned payload;
    logic [63:0] span, wide, unit, rounded, span_top;
    bit          eot;
    eot = it.end_of_text;
    pos = char_index;
    if (char_index != '1) char_index++;
    if (text_failed) begin
      if (eot) clear_text();
      return;
    end
    live_chars++;
    d = digit_of(it.character, alpha_sel);
    if (d < 0) begin
      push_error(ERR_INVALID_CHAR, pos, eot);
      return;
    end
    digit_acc = digit_acc * BASE + 64'(d);
    digit_count++;
    if (digit_count == 5) begin
      if (digit_acc > U32_ALL_ONES) begin
        push_error(ERR_GROUP_RANGE, pos, eot);
        return;
      end
      for (int i = 0; i < 4; i++) push_byte(8'(digit_acc >> (8*(3-i))), eot && i == 3);
      digit_acc   = '0;
      digit_count = 0;
      if (eot) clear_text();
      return;
    end
    if (!eot) return;
    if (digit_count == 1) begin
      push_error(ERR_SHORT_TAIL, pos, eot);
      return;
    end
    span = 64'd1;
    for (int k = 0; k < 5 - int'(digit_count); k++) span = span * BASE;
    wide = digit_acc * span;
    if (wide > U32_ALL_ONES) begin
      push_error(ERR_GROUP_RANGE, pos, eot);
      return;
    end
    payload  = digit_count - 1;
    unit     = 64'd1 << (8 * (4 - payload));
    rounded  = ((wide + unit - 1) / unit) * unit;
    span_top = wide + span - 1;
    if (rounded > span_top || rounded > U32_ALL_ONES) begin
      push_error(ERR_NONCANON, pos, eot);
      return;
    end
    for (int i = 0; i < int'(payload); i++)
      push_byte(8'(rounded >> (8*(3-i))), i == int'(payload) - 1);
    clear_text();
  endfunction

  // result check first, then prediction of the character accepted at this edge
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag($sformatf("unexpected result %s", fmt_result(out_data)));
      end else begin
        want = pending_results.pop_front();
        if (out_data.is_error !== want.is_error || out_data.error_code !== want.error_code ||
            out_data.data_byte !== want.data_byte || out_data.position !== want.position ||
            out_data.last_result !== want.last_result) begin
          flag($sformatf("expected %s, got %s", fmt_result(want), fmt_result(out_data)));
        end
      end
    end
    if (rst_n && in_valid && in_ready) decode_char(in_data);
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] ch, logic eot);
    in_item_t item;
    item.character   = ch;
    item.end_of_text = eot;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(bit mark_end);
    for (int i = 0; i < text_chars.size(); i++)
      send_char(text_chars[i], mark_end && i == text_chars.size() - 1);
    text_chars.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_alphabet(bit sel);
    logic [PDATA_W-1:0] got;
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ALPHA_ADDR;
    cfg_pwdata  <= PDATA_W'(sel);
    @(negedge clk) cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    alpha_sel = sel;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== PDATA_W'(sel))
      flag($sformatf("alphabet register read %08h, wrote %0d", got, sel));
  endtask

  // leading 'keep' digits of the five-digit spelling of v
  function automatic void push_digits(logic [63:0] v, int keep);
    logic [7:0] dig [5];
    for (int k = 4; k >= 0; k--) begin
      dig[k] = alpha_char(int'(v % BASE), alpha_sel);
      v      = v / BASE;
    end
    for (int k = 0; k < keep; k++) text_chars.push_back(dig[k]);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic void build_clean_text(int nbytes);
    logic [7:0]  bytes[$];
    logic [63:0] v;
    int          full, rest;
    for (int i = 0; i < nbytes; i++) bytes.push_back(rand_byte());
    full = nbytes / 4;
    rest = nbytes % 4;
    for (int g = 0; g < full; g++) begin
      v = {32'd0, bytes[4*g], bytes[4*g+1], bytes[4*g+2], bytes[4*g+3]};
      push_digits(v, 5);
    end
    if (rest != 0) begin
      v = '0;
      for (int j = 0; j < 4; j++) v = (v << 8) | (j < rest ? 64'(bytes[4*full+j]) : 64'd0);
      push_digits(v, rest + 1);
    end
  endfunction

  function automatic void build_random_text();
    int kind, len;
    kind = $urandom_range(99);
    if (kind < 65) begin
      build_clean_text($urandom_range(12, 1));
    end else if (kind < 75) begin
      build_clean_text($urandom_range(12, 1));
      text_chars[$urandom_range(text_chars.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 85) begin
      len = $urandom_range(11, 1);
      for (int i = 0; i < len; i++) text_chars.push_back(alpha_char($urandom_range(84), alpha_sel));
    end else if (kind < 93) begin
      build_clean_text($urandom_range(12, 1));
      if (text_chars.size() > 1 && $urandom_range(1)) void'(text_chars.pop_back());
      else text_chars.push_back(alpha_char($urandom_range(84), alpha_sel));
    end else begin
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) text_chars.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic test_groups();
    push_digits(64'h0000_0000_FFFF_FFFF, 5);
    push_digits(64'd0, 5);
    send_text(1'b1);
  endtask

  task automatic test_range_errors();
    push_digits(64'h0000_0001_0000_0000, 5);
    send_text(1'b1);
    text_chars = {"~", "~"};
    send_text(1'b1);
  endtask

  task automatic test_invalid_chars();
    text_chars = {"0", 8'hFF, "0", "0"};
    send_text(1'b1);
    text_chars = {8'h80};
    send_text(1'b1);
  endtask

  task automatic test_tails();
    text_chars = {"0"};
    send_text(1'b1);
    text_chars = {"0", "1"};
    send_text(1'b1);
    push_digits(64'h0000_0000_FF00_0000, 2);
    send_text(1'b1);
    push_digits(64'h0000_0000_FFFF_FF00, 4);
    send_text(1'b1);
  endtask

  task automatic test_alphabets();
    write_alphabet(1'b1);
    push_digits(64'h0000_0000_DEAD_BEEF, 5);
    send_text(1'b1);
    text_chars = {"~"};
    send_text(1'b1);
    // switch mid-text: the last digit is read with the new alphabet
    push_digits(64'h0000_0000_ABCD_0000, 2);
    send_text(1'b0);
    write_alphabet(1'b0);
    text_chars = {"z"};
    send_text(1'b1);
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    for (int t = 0; t < 8; t++) begin
      build_clean_text(4);
      send_text(1'b1);
    end
    wait_idle();
  endtask

  task automatic test_random(int gap_pct, int stall_pct, bit sel, int target);
    int unsigned start;
    write_alphabet(sel);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    start          = live_chars;
    while (live_chars - start < target) begin
      build_random_text();
      send_text(1'b1);
    end
    wait_idle();
  endtask

  initial begin
    clear_text();
    alpha_sel      = 1'b0;
    live_chars     = 0;
    mismatch_count = 0;
    hold_left      = 0;
    cycle_count    = 0;
    send_gap_pct   = 16;
    recv_stall_pct = 46;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(negedge clk);

    test_groups();
    test_range_errors();
    test_invalid_chars();
    test_tails();
    test_alphabets();
    test_backpressure();
    test_random(16, 46, 1'b0, 120);
    test_random(46, 16, 1'b1, 120);
    test_random(0, 0, 1'($urandom_range(1)), 120);

    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
